// File: src/rlfs_pkg.sv
// Shared constants for the RGB linear fade stepper: fixed-point widths,
// command codes and level limits. No dependencies.
package rlfs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int VAL_W     = 8;
    localparam int CNT_W     = 16;
    localparam int CMD_W     = 2;
    localparam int LEVEL_W   = VAL_W + FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(LEVEL_W + 1);

    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET = 2'd2;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL = {{VAL_W{1'b1}}, {FRAC_BITS{1'b0}}};

endpackage

// File: src/rlfs_div.sv
// Bit-serial restoring divider for one channel: one quotient bit per cycle.
// Depends on rlfs_pkg.
module rlfs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [rlfs_pkg::LEVEL_W-1:0]  i_dividend,
    input  logic [rlfs_pkg::CNT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [rlfs_pkg::LEVEL_W-1:0]  o_quotient
);

    logic [rlfs_pkg::LEVEL_W-1:0]   r_q;
    logic [rlfs_pkg::CNT_W-1:0]     r_rem;
    logic [rlfs_pkg::CNT_W-1:0]     r_div;
    logic [rlfs_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_busy;
    logic                           r_done;
    logic [rlfs_pkg::CNT_W:0]       trial;
    logic                           fits;

    // shift the next dividend bit into the partial remainder and try a subtract
    always_comb begin
        trial = {r_rem, r_q[rlfs_pkg::LEVEL_W-1]} - {1'b0, r_div};
        fits  = ~trial[rlfs_pkg::CNT_W] | r_rem[rlfs_pkg::CNT_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == rlfs_pkg::DIV_CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= rlfs_pkg::DIV_CNT_W'(rlfs_pkg::LEVEL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rlfs_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[rlfs_pkg::LEVEL_W-2:0], fits};
            if (fits) begin
                r_rem <= trial[rlfs_pkg::CNT_W-1:0];
            end else begin
                r_rem <= {r_rem[rlfs_pkg::CNT_W-2:0], r_q[rlfs_pkg::LEVEL_W-1]};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// File: src/rgb_linear_fade_stepper.sv
// Top level of the RGB linear fade stepper: command sequencer, level and
// previous-target registers, output register. Depends on rlfs_pkg, rlfs_div.
// A step that moves levels runs the three bit-serial dividers (ST_DIV) before
// the result state ST_FIN; other requests go straight from ST_IDLE to ST_FIN.
// One request at a time: o_in_ready is high only in ST_IDLE.
// A new request is taken while an earlier result waits in the output register.
// Reset (synchronous, active low) sets levels to 255.0 and previous targets to 0.
module rgb_linear_fade_stepper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rlfs_pkg::CMD_W-1:0]    i_command,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_red_value,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_green_value,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_blue_value,
    input  logic [rlfs_pkg::CNT_W-1:0]    i_step_count,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rlfs_pkg::VAL_W-1:0]    o_red_level,
    output logic [rlfs_pkg::VAL_W-1:0]    o_green_level,
    output logic [rlfs_pkg::VAL_W-1:0]    o_blue_level,
    output logic                          o_arrived
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam int LW = rlfs_pkg::LEVEL_W;
    localparam int VW = rlfs_pkg::VAL_W;
    localparam int FB = rlfs_pkg::FRAC_BITS;

    logic [1:0]                  r_state;
    logic [rlfs_pkg::CMD_W-1:0]  r_cmd;
    logic                        r_arr;
    logic [LW-1:0]               r_level [3];
    logic [VW-1:0]               r_prev  [3];
    logic [VW-1:0]               r_val   [3];
    logic [2:0]                  r_neg;
    logic                        r_out_valid;
    logic [VW-1:0]               r_out_level [3];
    logic                        r_out_arrived;

    logic [VW-1:0]               in_val   [3];
    logic [LW-1:0]               dividend [3];
    logic [LW-1:0]               quotient [3];
    logic [LW-1:0]               n_level  [3];
    logic [2:0]                  div_done;
    logic [2:0]                  at_target;
    logic [rlfs_pkg::CNT_W-1:0]  count_eff;
    logic                        accept;
    logic                        div_start;
    logic                        fin_go;

    function automatic logic [LW-1:0] step_level(input logic [LW-1:0] cur,
                                                 input logic [LW-1:0] tgt,
                                                 input logic [LW-1:0] q,
                                                 input logic          neg);
        logic signed [LW+1:0] c;
        logic signed [LW+1:0] t;
        logic signed [LW+1:0] n;
        logic                 snap;
        logic [LW-1:0]        res;
        c = signed'({2'b00, cur});
        t = signed'({2'b00, tgt});
        n = neg ? (c + signed'({2'b00, q})) : (c - signed'({2'b00, q}));
        snap = ((n < t) && (c > t)) || ((n > t) && (c < t)) || (c == t);
        if (snap) begin
            res = tgt;
        end else if (n < 0) begin
            res = '0;
        end else if (n > signed'({2'b00, rlfs_pkg::LEVEL_FULL})) begin
            res = rlfs_pkg::LEVEL_FULL;
        end else begin
            res = n[LW-1:0];
        end
        return res;
    endfunction

    assign in_val[0] = i_red_value;
    assign in_val[1] = i_green_value;
    assign in_val[2] = i_blue_value;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign count_eff  = (i_step_count == '0) ? rlfs_pkg::CNT_W'(1) : i_step_count;
    assign div_start  = accept && (i_command == rlfs_pkg::CMD_STEP) && !(&at_target);
    assign fin_go     = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);

    for (genvar g = 0; g < 3; g++) begin : g_chan
        logic [VW-1:0] absdiff;
        assign at_target[g] = (r_level[g] == {in_val[g], {FB{1'b0}}});
        assign absdiff      = (r_prev[g] >= in_val[g]) ? (r_prev[g] - in_val[g])
                                                       : (in_val[g] - r_prev[g]);
        assign dividend[g]  = {absdiff, {FB{1'b0}}};

        rlfs_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (div_start),
            .i_dividend (dividend[g]),
            .i_divisor  (count_eff),
            .o_done     (div_done[g]),
            .o_quotient (quotient[g])
        );

        always_comb begin
            case (r_cmd)
                rlfs_pkg::CMD_STEP: begin
                    n_level[g] = r_arr ? r_level[g]
                               : step_level(r_level[g], {r_val[g], {FB{1'b0}}},
                                            quotient[g], r_neg[g]);
                end
                rlfs_pkg::CMD_SET:   n_level[g] = {r_val[g], {FB{1'b0}}};
                rlfs_pkg::CMD_RESET: n_level[g] = rlfs_pkg::LEVEL_FULL;
                default:             n_level[g] = r_level[g];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_level[i] <= rlfs_pkg::LEVEL_FULL;
                r_prev[i]  <= '0;
            end
        end else begin
            if (o_out_valid && i_out_ready && !fin_go) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_state <= div_start ? ST_DIV : ST_FIN;
                    end
                end
                ST_DIV: begin
                    if (&div_done) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    // commit only when the output register can take the result
                    if (fin_go) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_level[i] <= n_level[i];
                            if (r_cmd == rlfs_pkg::CMD_STEP && r_arr) begin
                                r_prev[i] <= r_val[i];
                            end else if (r_cmd == rlfs_pkg::CMD_RESET) begin
                                r_prev[i] <= '0;
                            end
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // request payload and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= i_command;
            r_arr <= (i_command == rlfs_pkg::CMD_STEP) && (&at_target);
            for (int i = 0; i < 3; i++) begin
                r_val[i] <= in_val[i];
                r_neg[i] <= (r_prev[i] < in_val[i]);
            end
        end
        if (fin_go) begin
            r_out_arrived <= (r_cmd == rlfs_pkg::CMD_STEP) && r_arr;
            for (int i = 0; i < 3; i++) begin
                r_out_level[i] <= n_level[i][LW-1:FB];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_red_level   = r_out_level[0];
    assign o_green_level = r_out_level[1];
    assign o_blue_level  = r_out_level[2];
    assign o_arrived     = r_out_arrived;

endmodule

// File: src/rlfs_checker.sv
// Port-level checks for the RGB linear fade stepper, bound to the top level.
// Depends on rlfs_pkg and rgb_linear_fade_stepper.
module rlfs_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_ready,
    input  logic [rlfs_pkg::CMD_W-1:0]    i_command,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_red_value,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_green_value,
    input  logic [rlfs_pkg::VAL_W-1:0]    i_blue_value,
    input  logic [rlfs_pkg::CNT_W-1:0]    i_step_count,
    input  logic                          o_out_valid,
    input  logic                          i_out_ready,
    input  logic [rlfs_pkg::VAL_W-1:0]    o_red_level,
    input  logic [rlfs_pkg::VAL_W-1:0]    o_green_level,
    input  logic [rlfs_pkg::VAL_W-1:0]    o_blue_level,
    input  logic                          o_arrived
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_red_level)
            && $stable(o_green_level) && $stable(o_blue_level) && $stable(o_arrived))
        else $error("result changed while stalled");

    // a waiting request holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_command)
            && $stable(i_red_value) && $stable(i_green_value) && $stable(i_blue_value)
            && $stable(i_step_count))
        else $error("request changed while waiting");

    // reset leaves no result and an open input
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear the block");

    // one request at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input still open after a request");

    // a new result only appears as a request finishes
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a request in progress");

endmodule

bind rgb_linear_fade_stepper rlfs_checker u_rlfs_checker (.*);
